[hdl/tssm_pkg.sv]
// shared types, constants and codes for the three-stack shared memory block
package tssm_pkg;

	localparam int MAX_DEPTH   = 256;
	localparam int STACK_COUNT = 3;
	localparam int WORD_W      = 32;
	localparam int CFG_W       = 9;
	localparam int SEL_W       = 2;
	localparam int MEM_DEPTH   = STACK_COUNT * MAX_DEPTH;
	localparam int ADDR_W      = $clog2(MEM_DEPTH);
	localparam int DEPTH_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int CNT_W       = $clog2(MAX_DEPTH + 1);
	localparam int CAP_W       = (CNT_W > CFG_W) ? CNT_W : CFG_W;

	localparam logic [CFG_W-1:0] STACK_SIZE_RESET = CFG_W'(256);
	localparam logic [WORD_W-1:0] EMPTY_WORD = '1;

	typedef enum logic [1:0] {
		CMD_PUSH  = 2'd0,
		CMD_POP   = 2'd1,
		CMD_PEEK  = 2'd2,
		CMD_EMPTY = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_PUBLISH
	} state_t;

	typedef struct packed {
		cmd_t               command;
		logic [SEL_W-1:0]   stack_select;
		logic signed [WORD_W-1:0] push_value;
	} in_item_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] read_value;
		logic               was_empty;
		logic               push_dropped;
	} out_item_t;

	typedef struct packed {
		logic capture;
		logic execute;
		logic publish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_status_t;

endpackage

[hdl/three_stacks_shared_memory_top.sv]
// top level of the three-stack shared memory block
// Three LIFO stacks share one 768-word single-port memory; stack n owns words
// n*256 to n*256+255. Each transfer on the input channel carries a command
// (push, pop, peek, empty query), a stack number and a push word, and yields
// exactly one transfer on the output channel. A push onto a full stack is
// dropped and flagged, pop and peek on an empty stack return -1, and stack
// number three is ignored with an all-zero result. Capacity per stack is the
// stack_size register, saturated at 256, written through cfg_we/cfg_data. The
// user must write it only while the block is idle; the block does not enforce
// this. A command is captured into the command register, executed in the EXEC
// state by the single memory access and count update, then published into the
// output register. A new command is taken only in the idle state, as the
// controller visits its three states in turn around the one memory port, so
// one command is through before the next is taken. Publishing waits only while
// the output register holds a stalled result, which may wait there while the
// next command is taken and worked on. No clearing pass is needed after reset.
module three_stacks_shared_memory_top (
	input  logic                          clk,
	input  logic                          arst_n,
	// command channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  tssm_pkg::in_item_t            in_item,
	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output tssm_pkg::out_item_t           out_item,
	// stack_size register write
	input  logic                          cfg_we,
	input  logic [tssm_pkg::CFG_W-1:0]    cfg_data
);

	tssm_pkg::ctrl_cmd_t  ctrl;
	tssm_pkg::dp_status_t status;

	// sequencing of capture, memory access and publish
	tssm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.ctrl     (ctrl)
	);

	// counts, memory and result register
	tssm_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_item  (out_item),
		.ctrl      (ctrl),
		.status    (status)
	);

endmodule

[hdl/tssm_ctrl.sv]
// controller state machine: sequences capture, execute and publish of one command
module tssm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  tssm_pkg::dp_status_t status,
	output tssm_pkg::ctrl_cmd_t  ctrl
);

	tssm_pkg::state_t state_q, state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tssm_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			tssm_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_next = tssm_pkg::ST_EXEC;
				end
			end
			tssm_pkg::ST_EXEC: begin
				state_next = tssm_pkg::ST_PUBLISH;
			end
			tssm_pkg::ST_PUBLISH: begin
				if (status.out_free) begin
					state_next = tssm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = tssm_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall     = 1'b1;
		ctrl.capture = 1'b0;
		ctrl.execute = 1'b0;
		ctrl.publish = 1'b0;
		case (state_q)
			tssm_pkg::ST_IDLE: begin
				in_stall     = 1'b0;
				ctrl.capture = in_valid;
			end
			tssm_pkg::ST_EXEC: begin
				ctrl.execute = 1'b1;
			end
			tssm_pkg::ST_PUBLISH: begin
				ctrl.publish = status.out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

[hdl/tssm_datapath.sv]
// datapath: command register, stack counts, shared word memory and output register
module tssm_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tssm_pkg::in_item_t   in_item,
	input  logic                 cfg_we,
	input  logic [tssm_pkg::CFG_W-1:0] cfg_data,
	input  logic                 out_stall,
	output logic                 out_valid,
	output tssm_pkg::out_item_t  out_item,
	input  tssm_pkg::ctrl_cmd_t  ctrl,
	output tssm_pkg::dp_status_t status
);

	tssm_pkg::in_item_t item_q;
	logic [tssm_pkg::CFG_W-1:0] stack_size_q;
	logic [tssm_pkg::CNT_W-1:0] counts_q [tssm_pkg::STACK_COUNT];
	logic [tssm_pkg::WORD_W-1:0] mem [tssm_pkg::MEM_DEPTH];
	logic [tssm_pkg::WORD_W-1:0] rd_data_q;
	logic [tssm_pkg::WORD_W-1:0] res_value_q;
	logic                        res_use_mem_q;
	logic                        res_empty_q;
	logic                        res_dropped_q;
	logic                        out_valid_q;
	tssm_pkg::out_item_t         out_item_q;

	logic                        sel_ok;
	logic [tssm_pkg::CNT_W-1:0]  cnt;
	logic [tssm_pkg::CNT_W-1:0]  cnt_m1;
	logic [tssm_pkg::CAP_W-1:0]  cap;
	logic                        is_full;
	logic                        is_empty;
	logic                        is_read;
	logic                        push_ok;
	logic                        read_ok;
	logic [tssm_pkg::DEPTH_W-1:0] idx;
	logic [tssm_pkg::ADDR_W-1:0] mem_addr;

	// command fields held for the whole command
	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			item_q <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stack_size_q <= tssm_pkg::STACK_SIZE_RESET;
		end else if (cfg_we) begin
			stack_size_q <= cfg_data;
		end
	end

	always_comb begin
		sel_ok = item_q.stack_select < tssm_pkg::SEL_W'(tssm_pkg::STACK_COUNT);
		cnt    = '0;
		case (item_q.stack_select)
			2'd0:    cnt = counts_q[0];
			2'd1:    cnt = counts_q[1];
			2'd2:    cnt = counts_q[2];
			default: cnt = '0;
		endcase
		cnt_m1 = cnt - tssm_pkg::CNT_W'(1);
		if (tssm_pkg::CAP_W'(stack_size_q) > tssm_pkg::CAP_W'(tssm_pkg::MAX_DEPTH)) begin
			cap = tssm_pkg::CAP_W'(tssm_pkg::MAX_DEPTH);
		end else begin
			cap = tssm_pkg::CAP_W'(stack_size_q);
		end
		is_full  = tssm_pkg::CAP_W'(cnt) >= cap;
		is_empty = cnt == '0;
		is_read  = item_q.command inside {tssm_pkg::CMD_POP, tssm_pkg::CMD_PEEK};
		push_ok  = sel_ok && (item_q.command == tssm_pkg::CMD_PUSH) && !is_full;
		read_ok  = sel_ok && is_read && !is_empty;
		idx      = push_ok ? cnt[tssm_pkg::DEPTH_W-1:0] : cnt_m1[tssm_pkg::DEPTH_W-1:0];
		mem_addr = tssm_pkg::ADDR_W'(item_q.stack_select) * tssm_pkg::ADDR_W'(tssm_pkg::MAX_DEPTH)
			+ tssm_pkg::ADDR_W'(idx);
	end

	// shared word memory, one port, registered read
	always_ff @(posedge clk) begin
		if (ctrl.execute && push_ok) begin
			mem[mem_addr] <= item_q.push_value;
		end
		if (ctrl.execute && read_ok) begin
			rd_data_q <= mem[mem_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < tssm_pkg::STACK_COUNT; i++) begin
				counts_q[i] <= '0;
			end
		end else if (ctrl.execute) begin
			for (int i = 0; i < tssm_pkg::STACK_COUNT; i++) begin
				if (item_q.stack_select == tssm_pkg::SEL_W'(i)) begin
					if (push_ok) begin
						counts_q[i] <= cnt + tssm_pkg::CNT_W'(1);
					end else if (read_ok && (item_q.command == tssm_pkg::CMD_POP)) begin
						counts_q[i] <= cnt_m1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.execute) begin
			res_use_mem_q <= read_ok;
			res_value_q   <= (sel_ok && is_read && is_empty) ? tssm_pkg::EMPTY_WORD : '0;
			res_empty_q   <= sel_ok && is_empty;
			res_dropped_q <= sel_ok && (item_q.command == tssm_pkg::CMD_PUSH) && is_full;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.publish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.publish) begin
			out_item_q.read_value   <= res_use_mem_q ? rd_data_q : res_value_q;
			out_item_q.was_empty    <= res_empty_q;
			out_item_q.push_dropped <= res_dropped_q;
		end
	end

	assign status.out_free = !out_valid_q || !out_stall;
	assign out_valid       = out_valid_q;
	assign out_item        = out_item_q;

endmodule

[hdl/tssm_checker.sv]
// port-level checker for the three-stack shared memory block, with its bind
module tssm_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input tssm_pkg::out_item_t out_item
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled result changed or dropped");

	// one command at a time: after a transfer the input side is stalled
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second command taken while one is in work");

	// a dropped push reads no word
	a_drop_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.push_dropped |-> out_item.read_value == 0)
		else $error("dropped push carries data");

	// an empty stack answers only zero or the empty word
	a_empty_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.was_empty |->
			out_item.read_value == 0 || out_item.read_value == -1)
		else $error("empty stack returned a data word");

endmodule

bind three_stacks_shared_memory_top tssm_checker u_tssm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);
